FILE: hdl/nrmc_pkg.sv
// nrmc_pkg: shared constants, types and helpers of the rmc sentence parser
// depends on nothing; used by every module in hdl
package nrmc_pkg;

  localparam int COORD_FRAC_DIGITS_DEF = 6;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;

  localparam int HDR_LEN = 6;
  localparam logic [7:0] HDR_TEXT [HDR_LEN] = '{8'h24, 8'h47, 8'h50, 8'h52, 8'h4D, 8'h43};

  localparam int ACC_W = 37;
  localparam int SUM_W = 41;
  localparam int WGT_W = 27;
  localparam int PRD_W = 31;

  localparam logic [WGT_W-1:0] POW10_TAB [8] = '{
    27'd1, 27'd10, 27'd100, 27'd1000, 27'd10000, 27'd100000, 27'd1000000, 27'd10000000
  };

  localparam logic [3:0] FLD_HDR    = 4'd0;
  localparam logic [3:0] FLD_TIME   = 4'd1;
  localparam logic [3:0] FLD_STATUS = 4'd2;
  localparam logic [3:0] FLD_LAT    = 4'd3;
  localparam logic [3:0] FLD_LATH   = 4'd4;
  localparam logic [3:0] FLD_LON    = 4'd5;
  localparam logic [3:0] FLD_LONH   = 4'd6;
  localparam logic [3:0] FLD_SPEED  = 4'd7;
  localparam logic [3:0] FLD_COURSE = 4'd8;
  localparam logic [3:0] FLD_DATE   = 4'd9;
  localparam logic [3:0] FLD_MODE   = 4'd12;
  localparam logic [3:0] FLD_LAST   = 4'd15;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_BODY,
    PH_SUM,
    PH_SKIP
  } phase_t;

  typedef enum logic [2:0] {
    ERR_OK       = 3'd0,
    ERR_NO_START = 3'd1,
    ERR_MISMATCH = 3'd2,
    ERR_NO_STAR  = 3'd3,
    ERR_NOT_RMC  = 3'd4
  } err_t;

  typedef struct packed {
    logic             clr;
    logic             feed;
    logic [2:0]       scale;
    logic [ACC_W-1:0] lim;
  } acc_ctl_t;

  typedef struct packed {
    logic clr;
    logic body_xor;
    logic star_enter;
    logic sum_star;
    logic sum_byte;
  } cks_ctl_t;

  function automatic logic [63:0] pow10(input int n);
    logic [63:0] v;
    v = 64'd1;
    for (int i = 0; i < n && i < 19; i++) begin
      v = v * 64'd10;
    end
    return v;
  endfunction

endpackage

FILE: hdl/nmea_rmc_sentence_parser_core.sv
// nmea_rmc_sentence_parser_core: top level of the rmc sentence parser
// uses nrmc_pkg, nrmc_num_acc and nrmc_cksum
//
// channel  dir  handshake             payload
// in       in   in_valid/in_ready     in_rx_byte
// out      out  out_valid/out_ready   out_error_code .. out_fix_mode
//
// one byte per cycle while in_ready is high; each non-cr byte updates the parser state in the cycle it is taken
// a line feed loads the result register, one record per non-empty line
// while a record waits, bytes other than line feed are still taken
// synchronous active-low reset returns the parser to waiting for a line start
module nmea_rmc_sentence_parser_core #(
  parameter int COORD_FRAC_DIGITS = nrmc_pkg::COORD_FRAC_DIGITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_error_code,
  output logic [26:0] out_utc_time,
  output logic [7:0]  out_fix_status,
  output logic [33:0] out_latitude,
  output logic [7:0]  out_lat_hemisphere,
  output logic [36:0] out_longitude,
  output logic [7:0]  out_lon_hemisphere,
  output logic [23:0] out_ground_speed,
  output logic [16:0] out_course,
  output logic [26:0] out_fix_date,
  output logic [7:0]  out_fix_mode
);

  localparam logic [63:0] LAT_RAW = nrmc_pkg::pow10(4 + COORD_FRAC_DIGITS) - 64'd1;
  localparam logic [63:0] LON_RAW = nrmc_pkg::pow10(5 + COORD_FRAC_DIGITS) - 64'd1;
  localparam logic [36:0] LIM_LAT = (LAT_RAW > 64'h3FFFFFFFF) ? 37'h3FFFFFFFF : LAT_RAW[36:0];
  localparam logic [36:0] LIM_LON = (LON_RAW > 64'h1FFFFFFFFF) ? 37'h1FFFFFFFFF
                                                               : LON_RAW[36:0];
  localparam logic [2:0]  CRD_SCALE = 3'(COORD_FRAC_DIGITS);

  nrmc_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]  fld_r, fld_nxt;
  logic [2:0]  hp_r, hp_nxt;
  logic        hm_r, hm_nxt, hm_cl;
  logic        star_r, star_nxt;
  logic        start_r, start_nxt;

  logic [26:0] cap_time_r, cap_time_nxt, cl_time;
  logic [7:0]  cap_stat_r, cap_stat_nxt;
  logic [33:0] cap_lat_r, cap_lat_nxt, cl_lat;
  logic [7:0]  cap_lath_r, cap_lath_nxt;
  logic [36:0] cap_lon_r, cap_lon_nxt, cl_lon;
  logic [7:0]  cap_lonh_r, cap_lonh_nxt;
  logic [23:0] cap_spd_r, cap_spd_nxt, cl_spd;
  logic [16:0] cap_crs_r, cap_crs_nxt, cl_crs;
  logic [26:0] cap_date_r, cap_date_nxt, cl_date;
  logic [7:0]  cap_mode_r, cap_mode_nxt;

  logic        out_valid_r;
  logic [2:0]  err_r;
  logic [26:0] o_time_r;
  logic [7:0]  o_stat_r;
  logic [33:0] o_lat_r;
  logic [7:0]  o_lath_r;
  logic [36:0] o_lon_r;
  logic [7:0]  o_lonh_r;
  logic [23:0] o_spd_r;
  logic [16:0] o_crs_r;
  logic [26:0] o_date_r;
  logic [7:0]  o_mode_r;

  logic        take, close, feed, emit, clr_line, numeric;
  logic [2:0]  err_nxt;
  logic        sum_ok;
  logic [36:0] acc_val;
  nrmc_pkg::acc_ctl_t acc_ctl;
  nrmc_pkg::cks_ctl_t cks_ctl;

  assign in_ready = !out_valid_r || out_ready || (in_rx_byte != nrmc_pkg::CH_LF);
  assign take     = in_valid && in_ready && (in_rx_byte != nrmc_pkg::CH_CR);

  nrmc_num_acc u_acc (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (acc_ctl),
    .rx_byte (in_rx_byte),
    .acc_val (acc_val)
  );

  nrmc_cksum u_cks (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (cks_ctl),
    .rx_byte (in_rx_byte),
    .sum_ok  (sum_ok)
  );

  // sequencing of one byte
  always_comb begin
    phase_nxt = phase_r;
    close     = 1'b0;
    feed      = 1'b0;
    emit      = 1'b0;
    start_nxt = start_r;
    star_nxt  = star_r;
    cks_ctl   = '0;
    if (take) begin
      case (phase_r)
        nrmc_pkg::PH_IDLE: begin
          if (in_rx_byte == nrmc_pkg::CH_DOLLAR) begin
            start_nxt = 1'b1;
            feed      = 1'b1;
            phase_nxt = nrmc_pkg::PH_BODY;
          end else if (in_rx_byte != nrmc_pkg::CH_LF) begin
            phase_nxt = nrmc_pkg::PH_SKIP;
          end
        end
        nrmc_pkg::PH_BODY: begin
          if (in_rx_byte == nrmc_pkg::CH_LF) begin
            close = 1'b1;
            emit  = 1'b1;
          end else if (in_rx_byte == nrmc_pkg::CH_STAR) begin
            close              = 1'b1;
            star_nxt           = 1'b1;
            cks_ctl.star_enter = 1'b1;
            phase_nxt          = nrmc_pkg::PH_SUM;
          end else begin
            cks_ctl.body_xor = 1'b1;
            if (in_rx_byte == nrmc_pkg::CH_COMMA) begin
              close = 1'b1;
            end else begin
              feed = 1'b1;
            end
          end
        end
        nrmc_pkg::PH_SUM: begin
          if (in_rx_byte == nrmc_pkg::CH_LF) begin
            emit = 1'b1;
          end else if (in_rx_byte == nrmc_pkg::CH_STAR) begin
            cks_ctl.sum_star = 1'b1;
          end else begin
            cks_ctl.sum_byte = 1'b1;
          end
        end
        default: begin
          if (in_rx_byte == nrmc_pkg::CH_LF) begin
            emit = 1'b1;
          end
        end
      endcase
    end
    clr_line = emit;
    if (clr_line) begin
      phase_nxt = nrmc_pkg::PH_IDLE;
      start_nxt = 1'b0;
      star_nxt  = 1'b0;
    end
    cks_ctl.clr = clr_line;
  end

  // per-field format
  always_comb begin
    numeric       = 1'b0;
    acc_ctl.scale = 3'd2;
    acc_ctl.lim   = 37'd99999999;
    case (fld_r)
      nrmc_pkg::FLD_TIME: begin
        numeric = 1'b1;
      end
      nrmc_pkg::FLD_LAT: begin
        numeric       = 1'b1;
        acc_ctl.scale = CRD_SCALE;
        acc_ctl.lim   = LIM_LAT;
      end
      nrmc_pkg::FLD_LON: begin
        numeric       = 1'b1;
        acc_ctl.scale = CRD_SCALE;
        acc_ctl.lim   = LIM_LON;
      end
      nrmc_pkg::FLD_SPEED: begin
        numeric     = 1'b1;
        acc_ctl.lim = 37'd9999999;
      end
      nrmc_pkg::FLD_COURSE: begin
        numeric     = 1'b1;
        acc_ctl.lim = 37'd99999;
      end
      nrmc_pkg::FLD_DATE: begin
        numeric       = 1'b1;
        acc_ctl.scale = 3'd0;
      end
      default: begin
        numeric = 1'b0;
      end
    endcase
    acc_ctl.clr  = close || clr_line;
    acc_ctl.feed = feed && numeric;
  end

  // field capture, header check and error
  always_comb begin
    cl_time = cap_time_r;
    cl_lat  = cap_lat_r;
    cl_lon  = cap_lon_r;
    cl_spd  = cap_spd_r;
    cl_crs  = cap_crs_r;
    cl_date = cap_date_r;
    if (close) begin
      case (fld_r)
        nrmc_pkg::FLD_TIME:   cl_time = acc_val[26:0];
        nrmc_pkg::FLD_LAT:    cl_lat  = acc_val[33:0];
        nrmc_pkg::FLD_LON:    cl_lon  = acc_val;
        nrmc_pkg::FLD_SPEED:  cl_spd  = acc_val[23:0];
        nrmc_pkg::FLD_COURSE: cl_crs  = acc_val[16:0];
        nrmc_pkg::FLD_DATE:   cl_date = acc_val[26:0];
        default: begin
          cl_time = cap_time_r;
        end
      endcase
    end
    hm_cl = hm_r && !(close && fld_r == nrmc_pkg::FLD_HDR && hp_r != 3'(nrmc_pkg::HDR_LEN));

    if (!start_r) begin
      err_nxt = nrmc_pkg::ERR_NO_START;
    end else if (!star_r) begin
      err_nxt = nrmc_pkg::ERR_NO_STAR;
    end else if (!sum_ok) begin
      err_nxt = nrmc_pkg::ERR_MISMATCH;
    end else if (!hm_cl) begin
      err_nxt = nrmc_pkg::ERR_NOT_RMC;
    end else begin
      err_nxt = nrmc_pkg::ERR_OK;
    end

    cap_stat_nxt = cap_stat_r;
    cap_lath_nxt = cap_lath_r;
    cap_lonh_nxt = cap_lonh_r;
    cap_mode_nxt = cap_mode_r;
    hm_nxt       = hm_cl;
    hp_nxt       = hp_r;
    fld_nxt      = fld_r;
    if (feed) begin
      if (hp_r == 3'd0) begin
        case (fld_r)
          nrmc_pkg::FLD_STATUS: cap_stat_nxt = in_rx_byte;
          nrmc_pkg::FLD_LATH:   cap_lath_nxt = in_rx_byte;
          nrmc_pkg::FLD_LONH:   cap_lonh_nxt = in_rx_byte;
          nrmc_pkg::FLD_MODE:   cap_mode_nxt = in_rx_byte;
          default: begin
            cap_stat_nxt = cap_stat_r;
          end
        endcase
      end
      if (fld_r == nrmc_pkg::FLD_HDR) begin
        if (hp_r >= 3'(nrmc_pkg::HDR_LEN)) begin
          hm_nxt = 1'b0;
        end else if (nrmc_pkg::HDR_TEXT[hp_r] != in_rx_byte) begin
          hm_nxt = 1'b0;
        end
      end
      if (hp_r != 3'd7) begin
        hp_nxt = hp_r + 3'd1;
      end
    end
    if (close) begin
      hp_nxt = 3'd0;
      if (fld_r != nrmc_pkg::FLD_LAST) begin
        fld_nxt = fld_r + 4'd1;
      end
    end

    cap_time_nxt = cl_time;
    cap_lat_nxt  = cl_lat;
    cap_lon_nxt  = cl_lon;
    cap_spd_nxt  = cl_spd;
    cap_crs_nxt  = cl_crs;
    cap_date_nxt = cl_date;
    if (clr_line) begin
      cap_time_nxt = '0;
      cap_stat_nxt = '0;
      cap_lat_nxt  = '0;
      cap_lath_nxt = '0;
      cap_lon_nxt  = '0;
      cap_lonh_nxt = '0;
      cap_spd_nxt  = '0;
      cap_crs_nxt  = '0;
      cap_date_nxt = '0;
      cap_mode_nxt = '0;
      hm_nxt       = 1'b1;
      hp_nxt       = 3'd0;
      fld_nxt      = nrmc_pkg::FLD_HDR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= nrmc_pkg::PH_IDLE;
      fld_r       <= nrmc_pkg::FLD_HDR;
      hp_r        <= 3'd0;
      hm_r        <= 1'b1;
      star_r      <= 1'b0;
      start_r     <= 1'b0;
      cap_time_r  <= '0;
      cap_stat_r  <= '0;
      cap_lat_r   <= '0;
      cap_lath_r  <= '0;
      cap_lon_r   <= '0;
      cap_lonh_r  <= '0;
      cap_spd_r   <= '0;
      cap_crs_r   <= '0;
      cap_date_r  <= '0;
      cap_mode_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      fld_r       <= fld_nxt;
      hp_r        <= hp_nxt;
      hm_r        <= hm_nxt;
      star_r      <= star_nxt;
      start_r     <= start_nxt;
      cap_time_r  <= cap_time_nxt;
      cap_stat_r  <= cap_stat_nxt;
      cap_lat_r   <= cap_lat_nxt;
      cap_lath_r  <= cap_lath_nxt;
      cap_lon_r   <= cap_lon_nxt;
      cap_lonh_r  <= cap_lonh_nxt;
      cap_spd_r   <= cap_spd_nxt;
      cap_crs_r   <= cap_crs_nxt;
      cap_date_r  <= cap_date_nxt;
      cap_mode_r  <= cap_mode_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (emit) begin
      err_r <= err_nxt;
      if (err_nxt == nrmc_pkg::ERR_OK) begin
        o_time_r <= cl_time;
        o_stat_r <= cap_stat_r;
        o_lat_r  <= cl_lat;
        o_lath_r <= cap_lath_r;
        o_lon_r  <= cl_lon;
        o_lonh_r <= cap_lonh_r;
        o_spd_r  <= cl_spd;
        o_crs_r  <= cl_crs;
        o_date_r <= cl_date;
        o_mode_r <= cap_mode_r;
      end else begin
        o_time_r <= '0;
        o_stat_r <= '0;
        o_lat_r  <= '0;
        o_lath_r <= '0;
        o_lon_r  <= '0;
        o_lonh_r <= '0;
        o_spd_r  <= '0;
        o_crs_r  <= '0;
        o_date_r <= '0;
        o_mode_r <= '0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_error_code     = err_r;
  assign out_utc_time       = o_time_r;
  assign out_fix_status     = o_stat_r;
  assign out_latitude       = o_lat_r;
  assign out_lat_hemisphere = o_lath_r;
  assign out_longitude      = o_lon_r;
  assign out_lon_hemisphere = o_lonh_r;
  assign out_ground_speed   = o_spd_r;
  assign out_course         = o_crs_r;
  assign out_fix_date       = o_date_r;
  assign out_fix_mode       = o_mode_r;

endmodule

FILE: hdl/nrmc_num_acc.sv
// nrmc_num_acc: fixed-point decimal accumulator for one numeric field
// value is kept at full scale so padding needs no extra work; uses nrmc_pkg
module nrmc_num_acc (
  input  logic                     clk,
  input  logic                     rst_n,
  input  nrmc_pkg::acc_ctl_t       ctl,
  input  logic [7:0]               rx_byte,
  output logic [nrmc_pkg::ACC_W-1:0] acc_val
);

  logic [nrmc_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic [2:0]                 fc_r, fc_nxt;
  logic                       frac_r, frac_nxt;
  logic                       stop_r, stop_nxt;

  logic                       is_dig;
  logic [3:0]                 dig;
  logic [2:0]                 widx;
  logic [nrmc_pkg::WGT_W-1:0] wgt;
  logic [nrmc_pkg::PRD_W-1:0] prod;
  logic [nrmc_pkg::SUM_W-1:0] base;
  logic [nrmc_pkg::SUM_W-1:0] sum;
  logic [nrmc_pkg::ACC_W-1:0] pushed;

  always_comb begin
    is_dig = (rx_byte >= 8'h30) && (rx_byte <= 8'h39);
    dig    = rx_byte[3:0];
    widx   = frac_r ? (ctl.scale - 3'd1 - fc_r) : ctl.scale;
    wgt    = nrmc_pkg::POW10_TAB[widx];
    prod   = nrmc_pkg::PRD_W'(dig) * nrmc_pkg::PRD_W'(wgt);
    base   = frac_r ? nrmc_pkg::SUM_W'(acc_r)
                    : ({1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0});
    sum    = base + nrmc_pkg::SUM_W'(prod);
    pushed = (sum > nrmc_pkg::SUM_W'(ctl.lim)) ? ctl.lim : sum[nrmc_pkg::ACC_W-1:0];

    acc_nxt  = acc_r;
    fc_nxt   = fc_r;
    frac_nxt = frac_r;
    stop_nxt = stop_r;
    if (ctl.clr) begin
      acc_nxt  = '0;
      fc_nxt   = '0;
      frac_nxt = 1'b0;
      stop_nxt = 1'b0;
    end else if (ctl.feed && !stop_r) begin
      if (is_dig) begin
        if (!frac_r) begin
          acc_nxt = pushed;
        end else if (fc_r < ctl.scale) begin
          acc_nxt = pushed;
          fc_nxt  = fc_r + 3'd1;
        end
      end else if (rx_byte == nrmc_pkg::CH_DOT && !frac_r && ctl.scale != 3'd0) begin
        frac_nxt = 1'b1;
      end else begin
        stop_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      fc_r   <= '0;
      frac_r <= 1'b0;
      stop_r <= 1'b0;
    end else begin
      acc_r  <= acc_nxt;
      fc_r   <= fc_nxt;
      frac_r <= frac_nxt;
      stop_r <= stop_nxt;
    end
  end

  assign acc_val = acc_r;

endmodule

FILE: hdl/nrmc_cksum.sv
// nrmc_cksum: running xor and received hex checksum of one sentence
// uses nrmc_pkg for the control struct and characters
module nrmc_cksum (
  input  logic               clk,
  input  logic               rst_n,
  input  nrmc_pkg::cks_ctl_t ctl,
  input  logic [7:0]         rx_byte,
  output logic               sum_ok
);

  logic [7:0] run_r, run_nxt;
  logic [7:0] tail_r, tail_nxt;
  logic [7:0] rsum_r, rsum_nxt;
  logic       big_r, big_nxt;
  logic       live_r, live_nxt;
  logic       hex_ok;
  logic [3:0] hex_v;

  always_comb begin
    hex_ok = 1'b0;
    hex_v  = 4'd0;
    if (rx_byte >= 8'h30 && rx_byte <= 8'h39) begin
      hex_ok = 1'b1;
      hex_v  = rx_byte[3:0];
    end else if ((rx_byte >= 8'h41 && rx_byte <= 8'h46) ||
                 (rx_byte >= 8'h61 && rx_byte <= 8'h66)) begin
      hex_ok = 1'b1;
      hex_v  = rx_byte[3:0] + 4'd9;
    end

    run_nxt  = run_r;
    tail_nxt = tail_r;
    rsum_nxt = rsum_r;
    big_nxt  = big_r;
    live_nxt = live_r;
    if (ctl.clr) begin
      run_nxt  = '0;
      tail_nxt = '0;
      rsum_nxt = '0;
      big_nxt  = 1'b0;
      live_nxt = 1'b0;
    end else if (ctl.body_xor) begin
      run_nxt = run_r ^ rx_byte;
    end else if (ctl.star_enter || ctl.sum_star) begin
      if (ctl.sum_star) begin
        run_nxt = run_r ^ nrmc_pkg::CH_STAR ^ tail_r;
      end
      tail_nxt = '0;
      rsum_nxt = '0;
      big_nxt  = 1'b0;
      live_nxt = 1'b1;
    end else if (ctl.sum_byte) begin
      tail_nxt = tail_r ^ rx_byte;
      if (live_r) begin
        if (!hex_ok) begin
          live_nxt = 1'b0;
        end else begin
          if (rsum_r[7:4] != 4'd0) begin
            big_nxt = 1'b1;
          end
          rsum_nxt = {rsum_r[3:0], hex_v};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= '0;
      tail_r <= '0;
      rsum_r <= '0;
      big_r  <= 1'b0;
      live_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      tail_r <= tail_nxt;
      rsum_r <= rsum_nxt;
      big_r  <= big_nxt;
      live_r <= live_nxt;
    end
  end

  assign sum_ok = !big_r && (rsum_r == run_r);

endmodule

FILE: verif/testbench.sv
// testbench: self-checking bench for nmea_rmc_sentence_parser_core
// depends on nrmc_pkg and the parser rtl; drives byte requests and checks records
`timescale 1ns / 1ps

module testbench;

  localparam int FRAC = nrmc_pkg::COORD_FRAC_DIGITS_DEF;
  localparam longint LIMIT_CYCLES = 1500000;

  typedef struct {
    nrmc_pkg::err_t err;
    logic [26:0] utc;
    logic [7:0]  stat;
    logic [33:0] lat;
    logic [7:0]  lath;
    logic [36:0] lon;
    logic [7:0]  lonh;
    logic [23:0] spd;
    logic [16:0] crs;
    logic [26:0] date;
    logic [7:0]  mode;
  } record_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic [7:0] in_rx_byte = 0;
  logic out_ready = 0;
  logic in_ready, out_valid;
  logic [2:0]  out_error_code;
  logic [26:0] out_utc_time;
  logic [7:0]  out_fix_status;
  logic [33:0] out_latitude;
  logic [7:0]  out_lat_hemisphere;
  logic [36:0] out_longitude;
  logic [7:0]  out_lon_hemisphere;
  logic [23:0] out_ground_speed;
  logic [16:0] out_course;
  logic [26:0] out_fix_date;
  logic [7:0]  out_fix_mode;

  nmea_rmc_sentence_parser_core uut (.*);

  always #5 clk = ~clk;

  logic [7:0] byte_q [$];
  int         pause_mark [$];
  record_t    record_q [$];
  int         errors = 0;
  longint     cycles = 0;
  bit         hold_off_req = 0;
  bit         hold_done = 0;
  bit         mid_mark = 0;

  // parser state
  nrmc_pkg::phase_t ph;
  logic [3:0]  fidx;
  logic [2:0]  hpos;
  logic        hmatch, star, start_seen, tail_hex, big, nstop, infrac;
  logic [7:0]  rxor, rsum, txor;
  logic [63:0] acc;
  int          fcnt;
  logic [63:0] slots [10];

  function automatic int slot_idx(logic [3:0] f);
    if (f >= 1 && f <= 9) return f - 1;
    if (f == nrmc_pkg::FLD_MODE) return 9;
    return -1;
  endfunction

  function automatic bit numeric_fld(logic [3:0] f);
    return f == nrmc_pkg::FLD_TIME || f == nrmc_pkg::FLD_LAT || f == nrmc_pkg::FLD_LON ||
           f == nrmc_pkg::FLD_SPEED || f == nrmc_pkg::FLD_COURSE || f == nrmc_pkg::FLD_DATE;
  endfunction

  function automatic int frac_of(logic [3:0] f);
    if (f == nrmc_pkg::FLD_LAT || f == nrmc_pkg::FLD_LON) return FRAC;
    if (f == nrmc_pkg::FLD_DATE) return 0;
    return 2;
  endfunction

  function automatic logic [63:0] ten_pow(int n);
    logic [63:0] v;
    v = 1;
    repeat (n) v = v * 10;
    return v;
  endfunction

  function automatic logic [63:0] cap_of(logic [3:0] f);
    logic [63:0] v;
    case (f)
      nrmc_pkg::FLD_LAT: begin
        v = ten_pow(4 + FRAC) - 1;
        return v > 64'h3FFFFFFFF ? 64'h3FFFFFFFF : v;
      end
      nrmc_pkg::FLD_LON: begin
        v = ten_pow(5 + FRAC) - 1;
        return v > 64'h1FFFFFFFFF ? 64'h1FFFFFFFFF : v;
      end
      nrmc_pkg::FLD_SPEED: return 9999999;
      nrmc_pkg::FLD_COURSE: return 99999;
      default: return 99999999;
    endcase
  endfunction

  function automatic logic [63:0] push_digit(logic [63:0] a, int d, logic [63:0] lim);
    if (a > (lim - d) / 10) return lim;
    return a * 10 + d;
  endfunction

  function automatic void field_reset();
    hpos = 0; acc = 0; fcnt = 0; infrac = 0; nstop = 0;
  endfunction

  function automatic void line_reset();
    fidx = 0; hmatch = 1; rxor = 0; rsum = 0; star = 0; start_seen = 0;
    txor = 0; tail_hex = 0; big = 0;
    foreach (slots[i]) slots[i] = 0;
    field_reset();
  endfunction

  function automatic void field_end();
    int s;
    logic [63:0] a;
    s = slot_idx(fidx);
    if (fidx == nrmc_pkg::FLD_HDR && hpos != nrmc_pkg::HDR_LEN) hmatch = 0;
    if (s >= 0 && numeric_fld(fidx)) begin
      a = acc;
      for (int k = fcnt; k < frac_of(fidx); k++) a = push_digit(a, 0, cap_of(fidx));
      slots[s] = a;
    end
    if (fidx < nrmc_pkg::FLD_LAST) fidx++;
    field_reset();
  endfunction

  function automatic void take_char(logic [7:0] c);
    int s;
    s = slot_idx(fidx);
    if (fidx == nrmc_pkg::FLD_HDR &&
        (hpos >= nrmc_pkg::HDR_LEN || nrmc_pkg::HDR_TEXT[hpos] != c)) hmatch = 0;
    if (s >= 0 && !numeric_fld(fidx) && hpos == 0) slots[s] = c;
    if (s >= 0 && numeric_fld(fidx) && !nstop) begin
      if (c >= "0" && c <= "9") begin
        if (!infrac) acc = push_digit(acc, c - "0", cap_of(fidx));
        else if (fcnt < frac_of(fidx)) begin
          acc = push_digit(acc, c - "0", cap_of(fidx));
          fcnt++;
        end
      end else if (c == nrmc_pkg::CH_DOT && !infrac && frac_of(fidx) > 0) infrac = 1;
      else nstop = 1;
    end
    if (hpos < 7) hpos++;
  endfunction

  function automatic int hex_digit(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "A" && c <= "F") return c - "A" + 10;
    if (c >= "a" && c <= "f") return c - "a" + 10;
    return -1;
  endfunction

  function automatic void parse_byte(logic [7:0] c);
    record_t r;
    int h;
    if (c == nrmc_pkg::CH_CR) return;
    if (c == nrmc_pkg::CH_LF) begin
      if (ph == nrmc_pkg::PH_IDLE) return;
      if (ph == nrmc_pkg::PH_BODY) field_end();
      if (!start_seen) r.err = nrmc_pkg::ERR_NO_START;
      else if (!star) r.err = nrmc_pkg::ERR_NO_STAR;
      else if (big || rsum != rxor) r.err = nrmc_pkg::ERR_MISMATCH;
      else if (!hmatch) r.err = nrmc_pkg::ERR_NOT_RMC;
      else r.err = nrmc_pkg::ERR_OK;
      if (r.err != nrmc_pkg::ERR_OK) foreach (slots[i]) slots[i] = 0;
      r.utc = slots[0]; r.stat = slots[1]; r.lat = slots[2]; r.lath = slots[3];
      r.lon = slots[4]; r.lonh = slots[5]; r.spd = slots[6]; r.crs = slots[7];
      r.date = slots[8]; r.mode = slots[9];
      record_q.push_back(r);
      line_reset();
      ph = nrmc_pkg::PH_IDLE;
      return;
    end
    case (ph)
      nrmc_pkg::PH_IDLE: begin
        line_reset();
        if (c == nrmc_pkg::CH_DOLLAR) begin
          start_seen = 1; ph = nrmc_pkg::PH_BODY; take_char(c);
        end else ph = nrmc_pkg::PH_SKIP;
      end
      nrmc_pkg::PH_BODY: begin
        if (c == nrmc_pkg::CH_STAR) begin
          field_end();
          star = 1; rsum = 0; big = 0; tail_hex = 1; txor = 0; ph = nrmc_pkg::PH_SUM;
        end else begin
          rxor ^= c;
          if (c == nrmc_pkg::CH_COMMA) field_end();
          else take_char(c);
        end
      end
      nrmc_pkg::PH_SUM: begin
        if (c == nrmc_pkg::CH_STAR) begin
          rxor ^= nrmc_pkg::CH_STAR ^ txor;
          txor = 0; rsum = 0; big = 0; tail_hex = 1;
        end else begin
          h = hex_digit(c);
          txor ^= c;
          if (tail_hex) begin
            if (h < 0) tail_hex = 0;
            else begin
              if (rsum[7:4] != 0) big = 1;
              rsum = {rsum[3:0], 4'(h)};
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  // sentence building
  function automatic string rnd_num(int ip, int fp, bit dot);
    string s;
    s = "";
    repeat (ip) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
    if (dot) begin
      s = {s, "."};
      repeat (fp) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
    end
    return s;
  endfunction

  function automatic string rnd_field(int k);
    string s;
    int sel;
    sel = $urandom_range(0, 15);
    if (sel == 0) return "";
    if (sel == 1) begin
      s = "";
      repeat ($urandom_range(1, 14)) s = {s, string'(8'($urandom_range(32, 126)))};
      return s;
    end
    if (sel == 2) return rnd_num($urandom_range(8, 14), $urandom_range(0, 9), $urandom_range(0, 1));
    case (k)
      1: return rnd_num(6, $urandom_range(0, 4), $urandom_range(0, 1));
      2: return $urandom_range(0, 1) ? "A" : "V";
      3: return rnd_num(4, $urandom_range(0, 8), $urandom_range(0, 1));
      4: return $urandom_range(0, 1) ? "N" : "S";
      5: return rnd_num(5, $urandom_range(0, 8), $urandom_range(0, 1));
      6: return $urandom_range(0, 1) ? "E" : "W";
      7, 8: return rnd_num($urandom_range(1, 4), $urandom_range(0, 3), $urandom_range(0, 1));
      9: return rnd_num(6, 1, sel == 3);
      12: begin
        s = "ADEN";
        return s.substr($urandom_range(0, 3), 3);
      end
      default: return rnd_num(3, 1, 1);
    endcase
  endfunction

  function automatic string hex2(logic [7:0] v, bit lower);
    string s;
    s = $sformatf("%02h", v);
    return lower ? s : s.toupper();
  endfunction

  task automatic send_line(string body, int star_mode);
    logic [7:0] x;
    string s;
    x = 0;
    for (int i = 0; i < body.len(); i++) x ^= body[i];
    s = {"$", body};
    case (star_mode)
      0: s = {s, "*", hex2(x, $urandom_range(0, 1))};
      1: ;
      2: s = {s, "*", hex2(x ^ 8'($urandom_range(1, 255)), 0)};
      3: s = {s, "*1", hex2(x, 0)};
      4: s = {s, "*", hex2(x, 0), "x"};
      default: s = {s, "*"};
    endcase
    for (int i = 0; i < s.len(); i++) byte_q.push_back(s[i]);
    if ($urandom_range(0, 2) == 0) byte_q.push_back(nrmc_pkg::CH_CR);
    byte_q.push_back(nrmc_pkg::CH_LF);
  endtask

  task automatic send_rmc(int star_mode);
    string b;
    b = $urandom_range(0, 9) == 0 ? "GPGGA" : "GPRMC";
    for (int k = 1; k <= 12 + $urandom_range(0, 2); k++) begin
      if (k > 1 && $urandom_range(0, 30) == 0) break;
      b = {b, ",", rnd_field(k)};
    end
    send_line(b, star_mode);
  endtask

  task automatic send_raw(int n);
    repeat (n) byte_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // driver
  int gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        parse_byte(in_rx_byte);
        gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 16) : 0;
      end
      if ((in_valid && !in_ready)) ;
      else if (gap > 0) begin
        in_valid <= 0;
        gap--;
      end else if (pause_mark.size() > 0 && pause_mark[0] == 0) begin
        in_valid <= 0;
        if (record_q.size() == 0) void'(pause_mark.pop_front());
      end else if (byte_q.size() > 0) begin
        in_valid <= 1;
        in_rx_byte <= byte_q.pop_front();
        if (pause_mark.size() > 0) pause_mark[0]--;
      end else in_valid <= 0;
    end
  end

  // monitor
  task automatic report(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0d expected %0d", what, got, want);
  endtask

  int stall = 0;
  int hold_cnt = 0;
  always @(posedge clk) begin
    record_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (record_q.size() == 0) report("unexpected record", 0, 0);
        else begin
          e = record_q.pop_front();
          if (out_error_code != e.err) report("error_code", out_error_code, e.err);
          if (out_utc_time != e.utc) report("utc_time", out_utc_time, e.utc);
          if (out_fix_status != e.stat) report("fix_status", out_fix_status, e.stat);
          if (out_latitude != e.lat) report("latitude", out_latitude, e.lat);
          if (out_lat_hemisphere != e.lath) report("lat_hemisphere", out_lat_hemisphere, e.lath);
          if (out_longitude != e.lon) report("longitude", out_longitude, e.lon);
          if (out_lon_hemisphere != e.lonh) report("lon_hemisphere", out_lon_hemisphere, e.lonh);
          if (out_ground_speed != e.spd) report("ground_speed", out_ground_speed, e.spd);
          if (out_course != e.crs) report("course", out_course, e.crs);
          if (out_fix_date != e.date) report("fix_date", out_fix_date, e.date);
          if (out_fix_mode != e.mode) report("fix_mode", out_fix_mode, e.mode);
        end
        stall = $urandom_range(0, 3) == 0 ? $urandom_range(0, 16) : 0;
      end
      if (hold_off_req && !hold_done) begin
        hold_done <= 1;
        hold_cnt <= 600;
        out_ready <= 0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_ready <= 0;
      end else if (stall > 0) begin
        stall--;
        out_ready <= 0;
      end else out_ready <= 1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    ph = nrmc_pkg::PH_IDLE;
    line_reset();
    repeat (11) @(posedge clk);
    rst_n <= 1;
    // directed lines
    send_line("GPRMC,235959.99,A,9000.123456,N,18000.999999,W,999.99,359.99,311299,,,D", 0);
    send_line("GPRMC,000000,V,0000,S,00000,E,0,0,010100,1.0,E,N", 0);
    send_line("GPRMC,,,,,,,,,,,,", 0);
    send_line("GPRMC,1.23456,A,12.3456789012,N,1,E,-5,1e3,12.5,,,A,extra", 0);
    send_line({"GPRMC,99999999999999,A,99999999999999,N,999999999999999,E,",
               "99999999999,9999999,999999999999,,,"}, 0);
    send_line("GPRMC,123519,A", 1);
    send_line("GPRMC,123519,A", 2);
    send_line("GPRMC,123519,A", 3);
    send_line("GPRMC,123519,A", 4);
    send_line("GPRMC,123519,A", 5);
    send_line("GPGGA,123519,A", 0);
    send_line("GPRMCX,1,A", 0);
    send_line("GPRM", 0);
    send_line("", 0);
    send_line("GPRMC,1*2,A", 0);
    byte_q.push_back("X"); byte_q.push_back(8'h00); byte_q.push_back(8'hFF);
    byte_q.push_back(nrmc_pkg::CH_LF);
    byte_q.push_back(nrmc_pkg::CH_LF); byte_q.push_back(nrmc_pkg::CH_CR);
    byte_q.push_back(nrmc_pkg::CH_LF);
    send_line({"GPRMC,1", string'(8'h00), ",A"}, 0);
    byte_q.push_back(nrmc_pkg::CH_DOLLAR); byte_q.push_back(nrmc_pkg::CH_STAR);
    byte_q.push_back(8'h80); byte_q.push_back(nrmc_pkg::CH_STAR); byte_q.push_back("a");
    byte_q.push_back(nrmc_pkg::CH_LF);
    pause_mark.push_back(byte_q.size());
    // random part
    while (byte_q.size() < 1650) begin
      case ($urandom_range(0, 19))
        0: send_raw($urandom_range(1, 30));
        1: begin send_raw($urandom_range(0, 20)); byte_q.push_back(nrmc_pkg::CH_LF); end
        2: send_rmc($urandom_range(1, 5));
        default: send_rmc($urandom_range(0, 9) == 0 ? 2 : 0);
      endcase
      if (!mid_mark && byte_q.size() > pause_mark[0] + 300) begin
        pause_mark.push_back(byte_q.size() - pause_mark[0]);
        mid_mark = 1;
      end
    end
    byte_q.push_back(nrmc_pkg::CH_LF);
    // long receiver hold-off while bytes keep coming
    wait (byte_q.size() < 700);
    @(posedge clk);
    hold_off_req <= 1;
    wait (byte_q.size() == 0 && !in_valid);
    wait (record_q.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0 && record_q.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
